### src/obst_pkg.sv
// ----------------------------------------------------------------------------
// obst_pkg
// shared constants and types for the optimal bst cost block
// ----------------------------------------------------------------------------
package obst_pkg;

    localparam int MAX_KEYS = 64;
    localparam int KW = $clog2(MAX_KEYS + 1);
    localparam int IW = $clog2(MAX_KEYS);
    localparam int TW = 2 * IW;
    localparam int TDEPTH = MAX_KEYS * MAX_KEYS;
    localparam int WW = 16;
    localparam int CW = 32;
    localparam logic [CW-1:0] COST_MAX = {CW{1'b1}};

    typedef struct packed {
        logic        start;
        logic [KW-1:0] n;
    } fill_cmd_t;

    typedef struct packed {
        logic          done;
        logic [CW-1:0] cost;
        logic [KW-1:0] root;
    } fill_res_t;

endpackage

### src/optimal_bst_cost.sv
// ----------------------------------------------------------------------------
// optimal_bst_cost
// loads key weights, then fills optimal bst cost/root tables on the last key
// ----------------------------------------------------------------------------
//  channel   dir  signals                                      handshake
//  in        in   weight, last                                 in_valid / in_stall
//  out       out  min_cost, best_root, key_count, overflow     out_valid / out_stall
//
//  a non-last key is only stored; the last key starts the table fill, bound
//  by the single cost memory read port: per candidate root it reads the left
//  and right subtree costs, then compares; each range sum reads its weights
//  in turn; the result goes through the fill's done register, then out_valid
//  reset clears the control state only; memories hold no reset value
//  input stalls while the fill runs or a result waits to be taken
// ----------------------------------------------------------------------------
module optimal_bst_cost (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [15:0]             weight,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [31:0]             min_cost,
    output logic [6:0]              best_root,
    output logic [6:0]              key_count,
    output logic                    overflow
);
    import obst_pkg::*;

    logic [KW-1:0] count_reg, count_next;
    logic ovf_reg, ovf_next;
    logic pend_ovf_reg, pend_ovf_next;
    logic [KW-1:0] pend_n_reg, pend_n_next;
    logic out_valid_reg, out_valid_next;
    logic [CW-1:0] cost_out_reg;
    logic [KW-1:0] root_out_reg, n_out_reg;
    logic ovf_out_reg;

    logic accept, store;
    fill_cmd_t cmd;
    fill_res_t res;
    logic busy;
    logic [IW-1:0] w_raddr;
    logic [WW-1:0] w_rdata;

    assign in_stall = busy || res.done || out_valid_reg;
    assign accept = in_valid && !in_stall;
    assign store = accept && (count_reg < KW'(MAX_KEYS));

    obst_ram #(.WIDTH(WW), .DEPTH(MAX_KEYS)) u_weights (
        .clk(clk), .we(store), .waddr(count_reg[IW-1:0]), .wdata(weight),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    assign cmd.start = accept && last;
    assign cmd.n = store ? count_reg + 1'b1 : count_reg;

    obst_fill u_fill (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .res(res), .busy(busy),
        .w_raddr(w_raddr), .w_rdata(w_rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        ovf_next = ovf_reg;
        pend_n_next = pend_n_reg;
        pend_ovf_next = pend_ovf_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (store)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (last)
            begin
                pend_n_next = cmd.n;
                pend_ovf_next = ovf_reg || !store;
                count_next = '0;
                ovf_next = 1'b0;
            end
        end
        if (res.done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_n_reg <= pend_n_next;
        pend_ovf_reg <= pend_ovf_next;
        if (res.done)
        begin
            cost_out_reg <= res.cost;
            root_out_reg <= res.root;
            n_out_reg <= pend_n_reg;
            ovf_out_reg <= pend_ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_cost = cost_out_reg;
    assign best_root = 7'(root_out_reg);
    assign key_count = 7'(n_out_reg);
    assign overflow = ovf_out_reg;

endmodule

### src/obst_ram.sv
// ----------------------------------------------------------------------------
// obst_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module obst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/obst_fill.sv
// ----------------------------------------------------------------------------
// obst_fill
// table fill sequencer: walks lengths, ranges and roots over the memories
// ----------------------------------------------------------------------------
module obst_fill (
    input  logic                  clk,
    input  logic                  rst_n,
    input  obst_pkg::fill_cmd_t   cmd,
    output obst_pkg::fill_res_t   res,
    output logic                  busy,
    output logic [obst_pkg::IW-1:0] w_raddr,
    input  logic [obst_pkg::WW-1:0] w_rdata
);
    import obst_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DRD   = 9'b000000010,
        S_DWR   = 9'b000000100,
        S_WSUM  = 9'b000001000,
        S_LRD   = 9'b000010000,
        S_RRD   = 9'b000100000,
        S_CAND  = 9'b001000000,
        S_WRB   = 9'b010000000,
        S_FIN   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [KW-1:0] n_reg, h_reg, i_reg, k_reg, broot_reg, p_reg;
    logic [KW-1:0] n_next, h_next, i_next, k_next, broot_next, p_next;
    logic [CW+KW-1:0] wsum_reg, wsum_next;
    logic [CW-1:0] best_reg, best_next, left_reg, left_next;
    logic [CW-1:0] cost_res_reg, cost_res_next;
    logic [KW-1:0] root_res_reg, root_res_next;
    logic done_reg, done_next;

    logic c_we;
    logic [TW-1:0] c_waddr, c_raddr;
    logic [CW-1:0] c_wdata, c_rdata;
    logic [KW-1:0] r_wdata, r_rdata;

    logic [KW-1:0] j_val;
    logic [CW+KW:0] cand_wide;
    logic [CW-1:0] cand, lcost, rcost;

    function automatic logic [TW-1:0] taddr(input logic [KW-1:0] a, input logic [KW-1:0] b);
        logic [KW-1:0] a1, b1;
        a1 = a - 1'b1;
        b1 = b - 1'b1;
        return {a1[IW-1:0], b1[IW-1:0]};
    endfunction

    obst_ram #(.WIDTH(CW), .DEPTH(TDEPTH)) u_cost (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    obst_ram #(.WIDTH(KW), .DEPTH(TDEPTH)) u_root (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(r_wdata),
        .raddr(c_raddr), .rdata(r_rdata)
    );

    assign j_val = i_reg + h_reg;
    assign lcost = (k_reg == i_reg) ? '0 : left_reg;
    assign rcost = (k_reg == j_val) ? '0 : c_rdata;
    assign cand_wide = {{(KW+1){1'b0}}, lcost} + {{(KW+1){1'b0}}, rcost}
                     + {1'b0, wsum_reg};
    assign cand = (cand_wide > {{(KW+1){1'b0}}, COST_MAX}) ? COST_MAX : cand_wide[CW-1:0];

    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg; h_next = h_reg; i_next = i_reg; k_next = k_reg;
        broot_next = broot_reg; p_next = p_reg;
        wsum_next = wsum_reg; best_next = best_reg; left_next = left_reg;
        cost_res_next = cost_res_reg; root_res_next = root_res_reg;
        done_next = 1'b0;
        c_we = 1'b0;
        c_waddr = taddr(i_reg, i_reg);
        c_wdata = {{(CW-WW){1'b0}}, w_rdata};
        r_wdata = i_reg;
        c_raddr = taddr(i_reg, i_reg);
        w_raddr = IW'(p_reg - 1'b1);
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    n_next = cmd.n;
                    i_next = KW'(1);
                    p_next = KW'(1);
                    state_next = S_DRD;
                end
            end
            // diagonal: read weight, write cost(i,i) and root(i,i)
            S_DRD:
            begin
                w_raddr = IW'(i_reg - 1'b1);
                state_next = S_DWR;
            end
            S_DWR:
            begin
                c_we = 1'b1;
                if (i_reg == n_reg)
                begin
                    h_next = KW'(1);
                    i_next = KW'(1);
                    if (n_reg == KW'(1))
                    begin
                        cost_res_next = {{(CW-WW){1'b0}}, w_rdata};
                        state_next = S_FIN;
                    end
                    else
                    begin
                        p_next = KW'(1);
                        wsum_next = '0;
                        state_next = S_WSUM;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = S_DRD;
                end
            end
            // sum of weights i..j, pipelined one read per cycle
            S_WSUM:
            begin
                w_raddr = IW'(p_reg - 1'b1);
                if (p_reg != i_reg)
                begin
                    wsum_next = wsum_reg + {{(CW+KW-WW){1'b0}}, w_rdata};
                end
                if (p_reg == j_val + 1'b1)
                begin
                    k_next = i_reg;
                    best_next = COST_MAX;
                    broot_next = i_reg;
                    state_next = S_LRD;
                end
                else
                begin
                    p_next = p_reg + 1'b1;
                end
            end
            S_LRD:
            begin
                c_raddr = taddr(i_reg, k_reg - 1'b1);
                state_next = S_RRD;
            end
            S_RRD:
            begin
                left_next = c_rdata;
                c_raddr = taddr(k_reg + 1'b1, j_val);
                state_next = S_CAND;
            end
            S_CAND:
            begin
                if (cand < best_reg)
                begin
                    best_next = cand;
                    broot_next = k_reg;
                end
                if (k_reg == j_val)
                begin
                    state_next = S_WRB;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_LRD;
                end
            end
            S_WRB:
            begin
                c_we = 1'b1;
                c_waddr = taddr(i_reg, j_val);
                c_wdata = best_reg;
                r_wdata = broot_reg;
                wsum_next = '0;
                if (j_val == n_reg)
                begin
                    if (h_reg == n_reg - 1'b1)
                    begin
                        cost_res_next = best_reg;
                        root_res_next = broot_reg;
                        done_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        h_next = h_reg + 1'b1;
                        i_next = KW'(1);
                        p_next = KW'(1);
                        state_next = S_WSUM;
                    end
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    p_next = i_reg + 1'b1;
                    state_next = S_WSUM;
                end
            end
            // single key: cost is its weight, root is key one
            S_FIN:
            begin
                root_res_next = KW'(1);
                state_next = S_IDLE;
                done_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next; h_reg <= h_next; i_reg <= i_next; k_reg <= k_next;
        broot_reg <= broot_next; p_reg <= p_next;
        wsum_reg <= wsum_next; best_reg <= best_next; left_reg <= left_next;
        cost_res_reg <= cost_res_next; root_res_reg <= root_res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign res.done = done_reg;
    assign res.cost = cost_res_reg;
    assign res.root = root_res_reg;

endmodule
